// ===== rtl/field_header_decoder_top_defines.svh =====
// assertion macros used by the decoder top
`ifndef FIELD_HEADER_DECODER_TOP_DEFINES_SVH
`define FIELD_HEADER_DECODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define FHD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define FHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fhd_pkg.sv =====
package fhd_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned StartW = 31;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [4:0] InlineIdExt     = 5'h1F;
  localparam logic [2:0] FirstLengthCode = 3'd5;
  localparam logic [2:0] CodeTerminator  = 3'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LENGTH_BIG_ENDIAN = 1'b0,
    CFG_START_POSITION    = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_EXT  = 3'd1,
    PH_LEN  = 3'd2,
    PH_SKIP = 3'd3,
    PH_HALT = 3'd4
  } phase_e;

  typedef struct packed {
    logic              length_big_endian;
    logic [StartW-1:0] start_position;
  } cfg_t;

  typedef struct packed {
    logic [7:0]      field_id;
    logic [PosW-1:0] payload_length;
    logic [PosW-1:0] header_position;
    logic [PosW-1:0] data_position;
    logic            is_terminator;
    logic            range_error;
  } result_t;

  // payload byte count of a fixed size code
  function automatic logic [3:0] fixed_length(input logic [2:0] code);
    logic [3:0] len;
    case (code)
      3'd1:    len = 4'd1;
      3'd2:    len = 4'd2;
      3'd3:    len = 4'd4;
      3'd4:    len = 4'd8;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // number of explicit length bytes of a size code
  function automatic logic [2:0] length_byte_count(input logic [2:0] code);
    logic [2:0] cnt;
    case (code)
      3'd5:    cnt = 3'd1;
      3'd6:    cnt = 3'd2;
      3'd7:    cnt = 3'd4;
      default: cnt = 3'd0;
    endcase
    return cnt;
  endfunction

endpackage

// ===== rtl/fhd_ifs.sv =====
interface fhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;
  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

interface fhd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  field_id;
  logic [31:0] payload_length;
  logic [31:0] header_position;
  logic [31:0] data_position;
  logic        is_terminator;
  logic        range_error;
  modport source (output valid, output field_id, output payload_length,
                  output header_position, output data_position,
                  output is_terminator, output range_error, input ready);
  modport sink   (input valid, input field_id, input payload_length,
                  input header_position, input data_position,
                  input is_terminator, input range_error, output ready);
endinterface

interface fhd_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [30:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fhd_parser.sv =====
module fhd_parser
  import fhd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       stream_start_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] lead_pos_q, lead_pos_d;
  logic [7:0]      cur_id_q, cur_id_d;
  logic [2:0]      code_q, code_d;
  logic [PosW-1:0] len_acc_q, len_acc_d;
  logic [2:0]      len_left_q, len_left_d;
  logic [PosW-1:0] byte_pos_q, byte_pos_d;
  logic [PosW-1:0] skip_q, skip_d;

  phase_e          phase_eff;
  logic [PosW-1:0] pos, dp, len_f, skip_eff, acc_eff, acc_new, acc_le_part;
  logic [2:0]      left_eff, left_new, total;
  logic [1:0]      le_idx;
  logic [PosW:0]   end_sum;
  logic            fin, err;

  always_comb begin
    // stream start restarts parser and position before the byte is looked at
    phase_eff = stream_start_i ? PH_LEAD : phase_q;
    skip_eff  = stream_start_i ? '0 : skip_q;
    left_eff  = stream_start_i ? '0 : len_left_q;
    acc_eff   = stream_start_i ? '0 : len_acc_q;
    pos       = stream_start_i ? {1'b0, cfg_i.start_position} : byte_pos_q;

    phase_d    = phase_eff;
    lead_pos_d = lead_pos_q;
    cur_id_d   = cur_id_q;
    code_d     = code_q;
    len_acc_d  = acc_eff;
    len_left_d = left_eff;
    skip_d     = skip_eff;
    byte_pos_d = pos + 32'd1;

    total       = length_byte_count(code_q);
    le_idx      = 2'(total - left_eff);
    acc_le_part = {24'd0, data_byte_i} << {le_idx, 3'b000};
    acc_new     = cfg_i.length_big_endian ? {acc_eff[PosW-9:0], data_byte_i}
                                          : (acc_eff | acc_le_part);
    left_new    = left_eff - 3'd1;

    fin   = 1'b0;
    len_f = '0;

    case (phase_eff)
      PH_EXT: begin
        cur_id_d = data_byte_i;
        if (code_q < FirstLengthCode) begin
          fin   = 1'b1;
          len_f = {28'd0, fixed_length(code_q)};
        end else begin
          len_acc_d  = '0;
          len_left_d = total;
          phase_d    = PH_LEN;
        end
      end
      PH_LEN: begin
        len_acc_d  = acc_new;
        len_left_d = left_new;
        if (left_new == 3'd0 || total == 3'd0) begin
          fin   = 1'b1;
          len_f = acc_new;
        end
      end
      PH_SKIP: begin
        skip_d = skip_eff - 32'd1;
        if (skip_d == '0) begin
          phase_d = PH_LEAD;
        end
      end
      PH_HALT: begin
      end
      default: begin
        lead_pos_d = pos;
        cur_id_d   = {3'd0, data_byte_i[4:0]};
        code_d     = data_byte_i[7:5];
        if (data_byte_i[4:0] == InlineIdExt) begin
          phase_d = PH_EXT;
        end else if (data_byte_i[7:5] < FirstLengthCode) begin
          fin     = 1'b1;
          len_f   = {28'd0, fixed_length(data_byte_i[7:5])};
          phase_d = PH_LEAD;
        end else begin
          len_acc_d  = '0;
          len_left_d = length_byte_count(data_byte_i[7:5]);
          phase_d    = PH_LEN;
        end
      end
    endcase

    // end check: carry out or bit 31 set means past the position limit
    dp      = pos + 32'd1;
    end_sum = {1'b0, dp} + {1'b0, len_f};
    err     = end_sum[PosW] | end_sum[PosW-1];

    if (fin) begin
      if (err) begin
        phase_d = PH_HALT;
        skip_d  = '0;
      end else if (len_f == '0) begin
        phase_d = PH_LEAD;
      end else begin
        skip_d  = len_f;
        phase_d = PH_SKIP;
      end
    end

    res_valid_o           = fin;
    res_o.field_id        = (code_d == CodeTerminator) ? 8'd0 : cur_id_d;
    res_o.payload_length  = len_f;
    res_o.header_position = lead_pos_d;
    res_o.data_position   = dp;
    res_o.is_terminator   = (code_d == CodeTerminator);
    res_o.range_error     = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEAD;
      lead_pos_q <= '0;
      cur_id_q   <= '0;
      code_q     <= '0;
      len_acc_q  <= '0;
      len_left_q <= '0;
      byte_pos_q <= '0;
      skip_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      lead_pos_q <= lead_pos_d;
      cur_id_q   <= cur_id_d;
      code_q     <= code_d;
      len_acc_q  <= len_acc_d;
      len_left_q <= len_left_d;
      byte_pos_q <= byte_pos_d;
      skip_q     <= skip_d;
    end
  end

endmodule

// ===== rtl/field_header_decoder_top.sv =====
// channel | dir | beat                                     | handshake
// in_i    | in  | data_byte, stream_start                  | valid/ready
// out_o   | out | field_id, payload_length, header/data pos, | valid/ready
//         |     | is_terminator, range_error               |
// cfg_i   | in  | index, data                              | valid/ready, ready always high
//
// one byte a cycle sustained while out_o is not stalled; an input beat reaches its
// result beat through the input register, then parser logic into the result register
// a byte that completes a header gives one result beat, all other bytes give none
// reset clears the parser to expect a lead byte at position zero and both config regs
// a stalled result holds the result register; the input register still takes a beat
// when empty, so the stall reaches in_i.ready only once that beat is held
`include "field_header_decoder_top_defines.svh"

module field_header_decoder_top
  import fhd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  fhd_in_if.sink    in_i,
  fhd_out_if.source out_o,
  fhd_cfg_if.sink   cfg_i
);

  // configuration registers
  cfg_t cfg_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // result register
  logic    out_valid_q;
  result_t out_q;

  logic    advance, step, res_valid;
  result_t res;

  // the parser moves on a held byte whenever the result register can take whatever it yields
  assign advance  = !out_valid_q || out_o.ready;
  assign step     = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_LENGTH_BIG_ENDIAN: cfg_q.length_big_endian <= cfg_i.data[0];
        CFG_START_POSITION:    cfg_q.start_position    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input stage: valid bit reset, payload captured on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q  <= in_i.data_byte;
      in_start_q <= in_i.stream_start;
    end
  end

  fhd_parser u_parser (
    .clk_i,
    .rst_ni,
    .step_i         (step),
    .data_byte_i    (in_byte_q),
    .stream_start_i (in_start_q),
    .cfg_i          (cfg_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.field_id        = out_q.field_id;
  assign out_o.payload_length  = out_q.payload_length;
  assign out_o.header_position = out_q.header_position;
  assign out_o.data_position   = out_q.data_position;
  assign out_o.is_terminator   = out_q.is_terminator;
  assign out_o.range_error     = out_q.range_error;

  // a byte held in the input register is never dropped while the parser is stalled
  `FHD_ASSERT_NEXT(a_in_held, in_valid_q && !advance, in_valid_q, "input beat lost on stall")

  // terminators always report id zero
  `FHD_ASSERT_NOW(a_term_id, out_o.valid && out_o.is_terminator, out_o.field_id == 8'd0,
    "terminator with non-zero field id")

  // a result without range error ends inside the position limit
  `FHD_ASSERT_NOW(a_range_ok, out_o.valid && !out_o.range_error,
    ({1'b0, out_o.data_position} + {1'b0, out_o.payload_length}) <= 33'h0_7FFF_FFFF,
    "payload end past limit without range error")

endmodule
